[hw/rtl/hsc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package hsc_pkg;

    // Width of the configuration register that holds the parity bit count.
    localparam int CHECK_BITS_W = 3;

    // Parity bit count after reset, and the smallest count that is used.
    localparam int CHECK_BITS_RESET = 3;
    localparam int CHECK_BITS_MIN = 2;

    // Default for the largest parity bit count the block is built for.
    localparam int MAX_CHECK_BITS_DEF = 6;

    // Bit b of the 1-based codeword position of bit index j.
    function automatic logic pos_bit(input int j, input int b);
        int pos;
        pos = j + 1;
        return ((pos >> b) & 1) != 0;
    endfunction

    // 1-based codeword position of data bit k: the k-th position, counting
    // from zero, that is not a power of two.
    function automatic int data_pos(input int k);
        int cnt;
        int res;
        cnt = 0;
        res = 0;
        for (int p = 1; p < 256; p++) begin
            if ((p & (p - 1)) != 0) begin
                if (cnt == k && res == 0) begin
                    res = p;
                end
                cnt = cnt + 1;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/hamming_syndrome_corrector.sv]
`timescale 1ns / 1ps
`default_nettype none

// Hamming single-error-correcting decoder. Each transfer on the input channel
// carries one codeword of 2^r-1 bits (bit j at position j+1; higher bits are
// ignored), and each transfer on the output channel returns the corrected data
// bits packed lowest position first, the syndrome (the 1-based error position,
// 0 for none) and a flag that a bit was flipped. The parity bit count r is set
// by writing i_cfg_wdata with i_cfg_we; it resets to 3, values below 2 act as
// 2 and values above MAX_CHECK_BITS act as MAX_CHECK_BITS. Write it only while
// no codeword is in flight. The block is a two-register pipeline: a codeword
// is registered on input, decoded by one pass of XOR trees and a fixed gather,
// and registered on output, so it takes one codeword every cycle when the
// output is not stalled.
module hamming_syndrome_corrector
    import hsc_pkg::*;
#(
    parameter int MAX_CHECK_BITS = MAX_CHECK_BITS_DEF
) (
    input  wire logic                                             i_clk,
    input  wire logic                                             i_rst_n,
    input  wire logic                                             i_cfg_we,
    input  wire logic [CHECK_BITS_W-1:0]                          i_cfg_wdata,
    input  wire logic                                             i_valid,
    output logic                                                  o_ready,
    input  wire logic [(1 << MAX_CHECK_BITS) - 2:0]               i_codeword,
    output logic                                                  o_valid,
    input  wire logic                                             i_ready,
    output logic      [(1 << MAX_CHECK_BITS) - MAX_CHECK_BITS - 2:0] o_data_bits,
    output logic      [MAX_CHECK_BITS-1:0]                        o_syndrome,
    output logic                                                  o_corrected
);

    localparam int CW_W = (1 << MAX_CHECK_BITS) - 1;
    localparam int DATA_W = CW_W - MAX_CHECK_BITS;
    localparam logic [CHECK_BITS_W-1:0] R_MAX = CHECK_BITS_W'(MAX_CHECK_BITS);
    localparam logic [CHECK_BITS_W-1:0] R_MIN = CHECK_BITS_W'(CHECK_BITS_MIN);
    localparam logic [CHECK_BITS_W-1:0] R_RST = CHECK_BITS_W'(CHECK_BITS_RESET);

    logic [CHECK_BITS_W-1:0] r_check_bits;
    logic [CHECK_BITS_W-1:0] w_r_eff;

    logic            r_in_valid;
    logic [CW_W-1:0] r_codeword;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_data_bits;
    logic [MAX_CHECK_BITS-1:0] r_syndrome;
    logic              r_corrected;

    logic [CW_W-1:0]           w_masked;
    logic [MAX_CHECK_BITS-1:0] w_syndrome;
    logic [DATA_W-1:0]         w_data_bits;
    logic                      w_corrected;
    logic                      w_advance;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_bits <= R_RST;
        end else if (i_cfg_we) begin
            r_check_bits <= i_cfg_wdata;
        end
    end

    // Clamp the parity bit count to the supported range.
    always_comb begin
        if (r_check_bits < R_MIN) begin
            w_r_eff = R_MIN;
        end else if (r_check_bits > R_MAX) begin
            w_r_eff = R_MAX;
        end else begin
            w_r_eff = r_check_bits;
        end
    end

    // The result register moves when it is empty or its transfer completes.
    assign w_advance = !r_out_valid || i_ready;
    assign o_ready   = !r_in_valid || w_advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_codeword <= i_codeword;
        end
    end

    hsc_syndrome #(
        .MAX_CHECK_BITS(MAX_CHECK_BITS)
    ) u_syndrome (
        .i_codeword  (r_codeword),
        .i_check_bits(w_r_eff),
        .o_masked    (w_masked),
        .o_syndrome  (w_syndrome)
    );

    hsc_correct #(
        .MAX_CHECK_BITS(MAX_CHECK_BITS)
    ) u_correct (
        .i_masked    (w_masked),
        .i_syndrome  (w_syndrome),
        .i_check_bits(w_r_eff),
        .o_data_bits (w_data_bits),
        .o_corrected (w_corrected)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_valid) begin
            r_data_bits <= w_data_bits;
            r_syndrome  <= w_syndrome;
            r_corrected <= w_corrected;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_data_bits = r_data_bits;
    assign o_syndrome  = r_syndrome;
    assign o_corrected = r_corrected;

`ifndef NO_ASSERTIONS
    // The flag must agree with the syndrome of the same result.
    a_flag_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_corrected == (o_syndrome != '0)))
        else $error("corrected flag disagrees with syndrome");

    // A syndrome never points past the configured codeword length.
    a_syn_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_syndrome >> w_r_eff) == '0))
        else $error("syndrome beyond codeword length");

    // A codeword waiting behind a stalled result is not dropped.
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_ready) |=> r_in_valid)
        else $error("pending codeword lost under stall");
`endif

endmodule

`default_nettype wire

[hw/rtl/hsc_syndrome.sv]
`timescale 1ns / 1ps
`default_nettype none

module hsc_syndrome
    import hsc_pkg::*;
#(
    parameter int MAX_CHECK_BITS = MAX_CHECK_BITS_DEF
) (
    input  wire logic [(1 << MAX_CHECK_BITS) - 2:0] i_codeword,
    input  wire logic [CHECK_BITS_W-1:0]            i_check_bits,
    output logic      [(1 << MAX_CHECK_BITS) - 2:0] o_masked,
    output logic      [MAX_CHECK_BITS-1:0]          o_syndrome
);

    localparam int CW_W = (1 << MAX_CHECK_BITS) - 1;

    logic [CW_W-1:0] w_len_mask;
    logic [CW_W-1:0] w_sel [MAX_CHECK_BITS];

    // Keep only the bits that lie inside the configured codeword length.
    always_comb begin
        for (int j = 0; j < CW_W; j++) begin
            w_len_mask[j] = ((j + 1) >> i_check_bits) == 0;
        end
    end

    assign o_masked = i_codeword & w_len_mask;

    // Each syndrome bit is the parity of the bits whose position has that bit set.
    for (genvar b = 0; b < MAX_CHECK_BITS; b++) begin : g_syn
        for (genvar j = 0; j < CW_W; j++) begin : g_sel
            assign w_sel[b][j] = pos_bit(j, b);
        end
        assign o_syndrome[b] = ^(o_masked & w_sel[b]);
    end

endmodule

`default_nettype wire

[hw/rtl/hsc_correct.sv]
`timescale 1ns / 1ps
`default_nettype none

module hsc_correct
    import hsc_pkg::*;
#(
    parameter int MAX_CHECK_BITS = MAX_CHECK_BITS_DEF
) (
    input  wire logic [(1 << MAX_CHECK_BITS) - 2:0]              i_masked,
    input  wire logic [MAX_CHECK_BITS-1:0]                       i_syndrome,
    input  wire logic [CHECK_BITS_W-1:0]                         i_check_bits,
    output logic      [(1 << MAX_CHECK_BITS) - MAX_CHECK_BITS - 2:0] o_data_bits,
    output logic                                                 o_corrected
);

    localparam int CW_W = (1 << MAX_CHECK_BITS) - 1;
    localparam int DATA_W = CW_W - MAX_CHECK_BITS;

    logic [CW_W-1:0]   w_fixed;
    logic [DATA_W-1:0] w_gather;
    logic [DATA_W-1:0] w_data_mask;

    // Flip the bit that the syndrome points at; a zero syndrome flips nothing.
    always_comb begin
        for (int j = 0; j < CW_W; j++) begin
            w_fixed[j] = i_masked[j] ^ (i_syndrome == MAX_CHECK_BITS'(j + 1));
        end
    end

    // Data positions are the same for every length, so the gather is fixed wiring.
    for (genvar k = 0; k < DATA_W; k++) begin : g_gather
        assign w_gather[k] = w_fixed[data_pos(k) - 1];
    end

    // Zero the data bits above the configured data length.
    always_comb begin
        for (int k = 0; k < DATA_W; k++) begin
            w_data_mask[k] = k < ((1 << i_check_bits) - int'(i_check_bits) - 1);
        end
    end

    assign o_data_bits = w_gather & w_data_mask;
    assign o_corrected = i_syndrome != '0;

endmodule

`default_nettype wire
